// ===== rtl/gptc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gptc_pkg;

    // Fixed geometry of the gamma curves and of the output word
    localparam int CHAN_BITS  = 8;
    localparam int CURVE_LEN  = 256;
    localparam int WORD_W     = 32;
    localparam int PIXEL_BITS = 32;
    localparam int KEEP_BITS  = (PIXEL_BITS < WORD_W) ? PIXEL_BITS : WORD_W;
    localparam logic [WORD_W-1:0] KEEP_MASK =
        WORD_W'((64'd1 << KEEP_BITS) - 64'd1);

    // Defaults for the top-level parameters
    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int GAMMA_LEVELS_DEF    = 5;

    // Request codes
    localparam logic [1:0] REQ_GAMMA_WR = 2'd0;
    localparam logic [1:0] REQ_PAL_WR   = 2'd1;
    localparam logic [1:0] REQ_LOOKUP   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_RED_MASK   = 2'd0;
    localparam logic [1:0] CFG_GREEN_MASK = 2'd1;
    localparam logic [1:0] CFG_BLUE_MASK  = 2'd2;
    localparam logic [1:0] CFG_GAMMA_SEL  = 2'd3;

    localparam logic [WORD_W-1:0] RED_MASK_RST   = 32'h00FF_0000;
    localparam logic [WORD_W-1:0] GREEN_MASK_RST = 32'h0000_FF00;
    localparam logic [WORD_W-1:0] BLUE_MASK_RST  = 32'h0000_00FF;
    localparam logic [2:0]        GAMMA_SEL_RST  = 3'd0;

    // Placement of one channel byte: right shift, then left shift
    typedef struct packed {
        logic       en;
        logic [2:0] rsh;
        logic [4:0] lsh;
    } chan_place_t;

    typedef struct packed {
        logic [CHAN_BITS-1:0] r;
        logic [CHAN_BITS-1:0] g;
        logic [CHAN_BITS-1:0] b;
    } rgb_t;

    typedef struct packed {
        logic                 en;
        logic [2:0]           level;
        logic [CHAN_BITS-1:0] index;
        logic [CHAN_BITS-1:0] value;
    } gamma_wr_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } cmap_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/gamma_palette_to_truecolor_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Palette lookup to packed truecolor pixels, with gamma correction.
//
// Input channel (in_valid / in_stall) carries one request per accepted cycle:
//   gamma write  - stores gamma_value at table_index of curve gamma_level,
//   palette write- passes red/green/blue through the selected curve, places
//                  each channel under its mask and stores the word at
//                  table_index of the colour map,
//   lookup       - returns the colour map word for table_index on the output
//                  channel (out_valid / out_stall, payload pixel_word).
// Config channel (cfg_valid / cfg_ready) writes the three channel masks and
// the curve select; cfg_ready is always high. Write it only while idle.
// Throughput: one request per clock, any mix, while in_stall is low. A lookup
// waits in stage 1, then reads the colour map into the output stage, which
// raises out_valid. The lookup reads the colour map after a palette
// write of the previous request stores it, so the two never collide on the map.
// Reset clears the pipeline valids and loads the default masks and curve 0;
// gamma curves and colour map contents are undefined until written.
// When the receiver stalls, the result holds in the output stage. Gamma writes,
// palette writes and unused codes keep flowing; the next lookup waits in
// stage 1 and raises in_stall until the held result is taken.
module gamma_palette_to_truecolor_unit #(
    parameter int PALETTE_ENTRIES = gptc_pkg::PALETTE_ENTRIES_DEF,
    parameter int GAMMA_LEVELS    = gptc_pkg::GAMMA_LEVELS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // request channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [1:0]                     req_type,
    input  wire logic [2:0]                     gamma_level,
    input  wire logic [7:0]                     table_index,
    input  wire logic [7:0]                     gamma_value,
    input  wire logic [7:0]                     red,
    input  wire logic [7:0]                     green,
    input  wire logic [7:0]                     blue,
    // result channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [gptc_pkg::WORD_W-1:0]         pixel_word,
    // configuration channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [gptc_pkg::WORD_W-1:0]    cfg_data
);

    localparam int PAL_W = $clog2(PALETTE_ENTRIES);

    gptc_pkg::chan_place_t red_place;
    gptc_pkg::chan_place_t green_place;
    gptc_pkg::chan_place_t blue_place;
    logic [2:0]            gamma_sel;
    gptc_pkg::gamma_wr_t   gamma_wr;
    gptc_pkg::rgb_t        gamma_rgb;
    gptc_pkg::cmap_ctrl_t  cmap_ctrl;
    logic [gptc_pkg::WORD_W-1:0] cmap_rd;

    logic       in_acc;
    logic       s1_load;
    logic       s1_leave;
    logic       s1_free;
    logic       s2_free;
    logic       s2_load;

    // stage 1: palette write or lookup, gamma bytes ready
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic       s1_lookup_reg;
    logic       s1_hit_reg;
    logic [7:0] s1_index_reg;
    // stage 2: lookup result waiting for the receiver
    logic       s2_valid_reg;
    logic       s2_valid_next;
    logic       s2_hit_reg;

    assign cfg_ready = 1'b1;

    gptc_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (cfg_valid),
        .wr_index    (cfg_index),
        .wr_data     (cfg_data),
        .red_place   (red_place),
        .green_place (green_place),
        .blue_place  (blue_place),
        .gamma_sel   (gamma_sel)
    );

    // Handshake and flow: a palette write always drains from stage 1, a
    // lookup drains only when the output stage can take it.
    assign s2_free  = !s2_valid_reg || !out_stall;
    assign s1_leave = s1_valid_reg && (!s1_lookup_reg || s2_free);
    assign s1_free  = !s1_valid_reg || s1_leave;
    assign in_stall = !s1_free;
    assign in_acc   = in_valid && s1_free;
    assign s1_load  = in_acc && (req_type == gptc_pkg::REQ_PAL_WR ||
                                 req_type == gptc_pkg::REQ_LOOKUP);
    assign s2_load  = s1_valid_reg && s1_lookup_reg && s2_free;

    assign s1_valid_next = s1_load || (s1_valid_reg && !s1_leave);
    assign s2_valid_next = s2_load || (s2_valid_reg && out_stall);

    // Gamma writes commit at acceptance; out-of-range curves are dropped
    assign gamma_wr.en    = in_acc && (req_type == gptc_pkg::REQ_GAMMA_WR) &&
                            ({1'b0, gamma_level} < 4'(GAMMA_LEVELS));
    assign gamma_wr.level = gamma_level;
    assign gamma_wr.index = table_index;
    assign gamma_wr.value = gamma_value;

    gptc_gamma #(
        .GAMMA_LEVELS (GAMMA_LEVELS)
    ) u_gamma (
        .clk     (clk),
        .wr      (gamma_wr),
        .rd_en   (in_acc),
        .sel     (gamma_sel),
        .red     (red),
        .green   (green),
        .blue    (blue),
        .rd_data (gamma_rgb)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Advance the payload alongside the valids
    always_ff @(posedge clk) begin
        if (s1_load) begin
            s1_lookup_reg <= (req_type == gptc_pkg::REQ_LOOKUP);
            s1_hit_reg    <= ({1'b0, table_index} < 9'(PALETTE_ENTRIES));
            s1_index_reg  <= table_index;
        end
        if (s2_load) begin
            s2_hit_reg <= s1_hit_reg;
        end
    end

    // Out-of-range palette writes are dropped; out-of-range lookups give zero
    assign cmap_ctrl.wr_en = s1_valid_reg && !s1_lookup_reg && s1_hit_reg;
    assign cmap_ctrl.rd_en = s2_load;

    gptc_cmap #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_cmap (
        .clk         (clk),
        .ctrl        (cmap_ctrl),
        .index       (s1_index_reg[PAL_W-1:0]),
        .gamma_rgb   (gamma_rgb),
        .red_place   (red_place),
        .green_place (green_place),
        .blue_place  (blue_place),
        .rd_data     (cmap_rd)
    );

    assign out_valid  = s2_valid_reg;
    assign pixel_word = s2_hit_reg ? cmap_rd : '0;

endmodule

`default_nettype wire

// ===== rtl/gptc_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gptc_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr_en,
    input  wire logic [1:0]                  wr_index,
    input  wire logic [gptc_pkg::WORD_W-1:0] wr_data,
    output gptc_pkg::chan_place_t            red_place,
    output gptc_pkg::chan_place_t            green_place,
    output gptc_pkg::chan_place_t            blue_place,
    output logic [2:0]                       gamma_sel
);

    logic [gptc_pkg::WORD_W-1:0] red_mask_reg;
    logic [gptc_pkg::WORD_W-1:0] green_mask_reg;
    logic [gptc_pkg::WORD_W-1:0] blue_mask_reg;
    logic [2:0]                  gamma_sel_reg;
    gptc_pkg::chan_place_t       red_place_reg;
    gptc_pkg::chan_place_t       green_place_reg;
    gptc_pkg::chan_place_t       blue_place_reg;

    // Set-bit count, summed a nibble at a time
    function automatic logic [5:0] ones32(input logic [31:0] m);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + 6'(m[4*i]) + 6'(m[4*i+1]) + 6'(m[4*i+2]) + 6'(m[4*i+3]);
        end
        return n;
    endfunction

    function automatic gptc_pkg::chan_place_t derive(input logic [31:0] m);
        gptc_pkg::chan_place_t p;
        logic [5:0]            pc;
        logic [5:0]            tz;
        logic [31:0]           low;
        pc    = ones32(m);
        low   = m & (~m + 32'd1);
        tz    = ones32(low - 32'd1);
        p.en  = (m != '0);
        p.rsh = (pc < 6'd8) ? 3'(6'd8 - pc) : 3'd0;
        p.lsh = (pc > 6'd8) ? 5'(pc - 6'd8 + tz) : tz[4:0];
        return p;
    endfunction

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            red_mask_reg   <= gptc_pkg::RED_MASK_RST;
            green_mask_reg <= gptc_pkg::GREEN_MASK_RST;
            blue_mask_reg  <= gptc_pkg::BLUE_MASK_RST;
            gamma_sel_reg  <= gptc_pkg::GAMMA_SEL_RST;
        end
        else if (wr_en) begin
            case (wr_index)
                gptc_pkg::CFG_RED_MASK:   red_mask_reg   <= wr_data;
                gptc_pkg::CFG_GREEN_MASK: green_mask_reg <= wr_data;
                gptc_pkg::CFG_BLUE_MASK:  blue_mask_reg  <= wr_data;
                gptc_pkg::CFG_GAMMA_SEL:  gamma_sel_reg  <= wr_data[2:0];
                default:                  gamma_sel_reg  <= gamma_sel_reg;
            endcase
        end
    end

    // Shift amounts are registered from the masks and follow them in the next cycle
    always_ff @(posedge clk) begin
        red_place_reg   <= derive(red_mask_reg);
        green_place_reg <= derive(green_mask_reg);
        blue_place_reg  <= derive(blue_mask_reg);
    end

    assign red_place   = red_place_reg;
    assign green_place = green_place_reg;
    assign blue_place  = blue_place_reg;
    assign gamma_sel   = gamma_sel_reg;

endmodule

`default_nettype wire

// ===== rtl/gptc_gamma.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gptc_gamma #(
    parameter int GAMMA_LEVELS = gptc_pkg::GAMMA_LEVELS_DEF
) (
    input  wire logic                           clk,
    input  wire gptc_pkg::gamma_wr_t            wr,
    input  wire logic                           rd_en,
    input  wire logic [2:0]                     sel,
    input  wire logic [gptc_pkg::CHAN_BITS-1:0] red,
    input  wire logic [gptc_pkg::CHAN_BITS-1:0] green,
    input  wire logic [gptc_pkg::CHAN_BITS-1:0] blue,
    output gptc_pkg::rgb_t                      rd_data
);

    localparam int LVL_W  = (GAMMA_LEVELS > 1) ? $clog2(GAMMA_LEVELS) : 1;
    localparam int ADDR_W = LVL_W + gptc_pkg::CHAN_BITS;
    localparam int DEPTH  = GAMMA_LEVELS * gptc_pkg::CURVE_LEN;
    localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(GAMMA_LEVELS - 1);

    // One copy of the curves per color channel, so each has a single read port
    logic [gptc_pkg::CHAN_BITS-1:0] gam_r_mem [DEPTH];
    logic [gptc_pkg::CHAN_BITS-1:0] gam_g_mem [DEPTH];
    logic [gptc_pkg::CHAN_BITS-1:0] gam_b_mem [DEPTH];
    gptc_pkg::rgb_t                 rd_data_reg;
    logic [LVL_W-1:0]               sel_sat;
    logic [ADDR_W-1:0]              waddr;

    // Saturate the curve number to the last curve
    assign sel_sat = ({1'b0, sel} >= 4'(GAMMA_LEVELS)) ? LAST_LVL : sel[LVL_W-1:0];
    assign waddr   = {wr.level[LVL_W-1:0], wr.index};

    always_ff @(posedge clk) begin
        if (wr.en) begin
            gam_r_mem[waddr] <= wr.value;
            gam_g_mem[waddr] <= wr.value;
            gam_b_mem[waddr] <= wr.value;
        end
    end

    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data_reg.r <= gam_r_mem[{sel_sat, red}];
            rd_data_reg.g <= gam_g_mem[{sel_sat, green}];
            rd_data_reg.b <= gam_b_mem[{sel_sat, blue}];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/gptc_cmap.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gptc_cmap #(
    parameter int PALETTE_ENTRIES = gptc_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic                                 clk,
    input  wire gptc_pkg::cmap_ctrl_t                 ctrl,
    input  wire logic [$clog2(PALETTE_ENTRIES)-1:0]   index,
    input  wire gptc_pkg::rgb_t                       gamma_rgb,
    input  wire gptc_pkg::chan_place_t                red_place,
    input  wire gptc_pkg::chan_place_t                green_place,
    input  wire gptc_pkg::chan_place_t                blue_place,
    output logic [gptc_pkg::WORD_W-1:0]               rd_data
);

    logic [gptc_pkg::WORD_W-1:0] cmap_mem [PALETTE_ENTRIES];
    logic [gptc_pkg::WORD_W-1:0] rd_data_reg;
    logic [gptc_pkg::WORD_W-1:0] packed_word;

    function automatic logic [gptc_pkg::WORD_W-1:0] place(
        input logic [gptc_pkg::CHAN_BITS-1:0] val,
        input gptc_pkg::chan_place_t          p
    );
        logic [gptc_pkg::WORD_W+gptc_pkg::CHAN_BITS-1:0] w;
        w = {{gptc_pkg::WORD_W{1'b0}}, val >> p.rsh} << p.lsh;
        return p.en ? (w[gptc_pkg::WORD_W-1:0] & gptc_pkg::KEEP_MASK) : '0;
    endfunction

    assign packed_word = place(gamma_rgb.r, red_place)
                       | place(gamma_rgb.g, green_place)
                       | place(gamma_rgb.b, blue_place);

    always_ff @(posedge clk) begin
        if (ctrl.wr_en) begin
            cmap_mem[index] <= packed_word;
        end
    end

    always_ff @(posedge clk) begin
        if (ctrl.rd_en) begin
            rd_data_reg <= cmap_mem[index];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/gptc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gptc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic [1:0]  req_type,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] pixel_word,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_word))
        else $error("stalled result changed");

    // Input backpressure only comes from a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // A new result is preceded by an accepted lookup or a held one
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |->
            $past(in_valid && !in_stall && req_type == gptc_pkg::REQ_LOOKUP, 2) ||
            $past(in_stall, 2))
        else $error("result without a lookup request");

    // The config channel never blocks
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write not taken");

endmodule

bind gamma_palette_to_truecolor_unit gptc_checker u_gptc_checker (.*);

`default_nettype wire
